// ===== design/epwm_pkg.sv =====
package epwm_pkg;

  localparam int unsigned MemKbW  = 13;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned PhysW   = 21;
  localparam int unsigned PortW   = 16;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    CMD_PORT_RD = 2'd0,
    CMD_PORT_WR = 2'd1,
    CMD_MEM     = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MEM_SIZE_KB = 1'b0,
    CFG_VARIANT     = 1'b1
  } cfg_idx_t;

  localparam logic [13:0] PAGE_PORT = 14'h0208;
  localparam logic [13:0] CTRL_PORT = 14'h0209;

  localparam logic [MemKbW-1:0] SMALL_MEM_KB = 13'd640;

  localparam logic [7:0] PAGE_RESET = 8'h7F;
  localparam logic [7:0] NO_DATA    = 8'hFF;

  // Window start addresses in units of 16 KB.
  localparam logic [5:0] UNPLACED_SEG = 6'h38;
  localparam logic [5:0] PLACED_SEG   = 6'h30;

  localparam logic [PhysW-1:0] BASE_V0 = 21'h70000;
  localparam logic [PhysW-1:0] BASE_V1 = 21'h30000;

  typedef struct packed {
    logic             win_hit;
    logic [PhysW-1:0] phys_addr;
    logic             phys_valid;
  } xlate_res_t;

endpackage

// ===== design/epwm_xlate.sv =====
module epwm_xlate (
  input  logic [epwm_pkg::AddrW-1:0]  mem_addr,
  input  logic [7:0]                  page,
  input  logic [3:0]                  base_index,
  input  logic                        windows_placed,
  input  logic [epwm_pkg::MemKbW-1:0] mem_size_kb,
  input  logic                        machine_variant,
  output epwm_pkg::xlate_res_t        res
);

  logic [1:0]                 win;
  logic [3:0]                 rel;
  logic [5:0]                 start_seg;
  logic [7:0]                 sum_v0;
  logic [8:0]                 sum_v1;
  logic [epwm_pkg::PhysW-1:0] base;
  logic [epwm_pkg::PhysW-1:0] xlated;
  logic [22:0]                limit;

  assign win = mem_addr[15:14];
  assign rel = base_index + 4'd4 - {2'b00, win};

  always_comb begin
    if (!windows_placed) begin
      start_seg = epwm_pkg::UNPLACED_SEG + {4'd0, win};
    end else begin
      start_seg = epwm_pkg::PLACED_SEG + {4'd0, win} + {2'b00, rel[3:2], 2'b00};
    end
  end

  // The base wraps on the low bits of the memory size, as the original hardware does.
  assign sum_v0 = mem_size_kb[7:0] + 8'd64;
  assign sum_v1 = mem_size_kb[8:0] + 9'd320;

  always_comb begin
    if (!machine_variant) begin
      base = epwm_pkg::BASE_V0 + {3'd0, sum_v0, 10'd0};
    end else begin
      base = epwm_pkg::BASE_V1 + {2'd0, sum_v1, 10'd0};
    end
  end

  assign xlated = base + {3'd0, page[3:0], 14'd0} + {2'd0, page[6], 18'd0}
                  + {7'd0, mem_addr[13:0]};
  assign limit  = {mem_size_kb, 10'd0};

  always_comb begin
    res.win_hit    = page[7] && (mem_addr[19:14] == start_seg);
    res.phys_addr  = res.win_hit ? xlated : {1'b0, mem_addr};
    res.phys_valid = res.win_hit && ({2'b00, xlated} < limit);
  end

endmodule

// ===== design/ems_page_window_mapper.sv =====
// Expanded-memory page window mapper.
// Input channel (in_valid/in_stall) carries one command per transaction: a port
// read, a port write, a memory access or a no-op. Every transaction returns
// exactly one result on the output channel (out_valid/out_stall): the port hit
// and read data, or the window hit, translated address and its validity.
// The result of an accepted transaction is registered and presented in the
// next cycle. One transaction per cycle is sustained while the receiver does
// not stall; the only storage between the channels is the single result register.
// When the receiver stalls with a result waiting, in_stall is raised until the
// result is taken; the result register then holds its contents unchanged.
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// the installed memory size (index 0) or the machine variant (index 1); write
// it only while no transaction is outstanding.
// Synchronous reset sets the page registers to 0x7F, the control registers to
// 0x80/0x80/0x80/0x00, parks the windows at 0xE0000, selects 640 KB and the
// original variant, and empties the result register.
module ems_page_window_mapper (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [epwm_pkg::PortW-1:0]   in_io_port,
  input  logic [7:0]                   in_wdata,
  input  logic [epwm_pkg::AddrW-1:0]   in_mem_addr,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_io_hit,
  output logic [7:0]                   out_io_rdata,
  output logic                         out_win_hit,
  output logic [epwm_pkg::PhysW-1:0]   out_phys_addr,
  output logic                         out_phys_valid,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [epwm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [epwm_pkg::MemKbW-1:0]  cfg_wdata
);

  logic [epwm_pkg::MemKbW-1:0] mem_size_kb_r;
  logic                        machine_variant_r;
  logic [7:0]                  page_r [4];
  logic [7:0]                  ctrl_r [4];
  logic [3:0]                  base_index_r;
  logic                        windows_placed_r;

  logic                        out_valid_r;
  logic                        io_hit_r;
  logic [7:0]                  io_rdata_r;
  logic                        win_hit_r;
  logic [epwm_pkg::PhysW-1:0]  phys_addr_r;
  logic                        phys_valid_r;

  logic                        accept;
  epwm_pkg::cmd_t              cmd;
  logic [13:0]                 port_low;
  logic [1:0]                  sel;
  logic                        io_cmd;
  logic                        io_hit;
  logic                        is_page;
  logic [7:0]                  io_rdata;
  logic                        page_wr;
  logic                        ctrl_wr;
  logic [3:0]                  base_index_nxt;
  epwm_pkg::xlate_res_t        xres;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  assign cmd      = epwm_pkg::cmd_t'(in_cmd);
  assign port_low = in_io_port[13:0];
  assign sel      = in_io_port[15:14];
  assign is_page  = (port_low == epwm_pkg::PAGE_PORT);
  assign io_cmd   = (cmd == epwm_pkg::CMD_PORT_RD) || (cmd == epwm_pkg::CMD_PORT_WR);
  assign io_hit   = io_cmd && (mem_size_kb_r > epwm_pkg::SMALL_MEM_KB)
                    && (is_page || (port_low == epwm_pkg::CTRL_PORT));
  assign page_wr  = accept && io_hit && (cmd == epwm_pkg::CMD_PORT_WR) && is_page;
  assign ctrl_wr  = accept && io_hit && (cmd == epwm_pkg::CMD_PORT_WR) && !is_page;

  always_comb begin
    if (io_hit && (cmd == epwm_pkg::CMD_PORT_RD)) begin
      io_rdata = is_page ? page_r[sel] : ctrl_r[sel];
    end else begin
      io_rdata = epwm_pkg::NO_DATA;
    end
  end

  // The base index takes bit 7 of every control register, the new byte included.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      base_index_nxt[k] = (sel == 2'(k)) ? in_wdata[7] : ctrl_r[k][7];
    end
  end

  epwm_xlate u_xlate (
    .mem_addr        (in_mem_addr),
    .page            (page_r[in_mem_addr[15:14]]),
    .base_index      (base_index_r),
    .windows_placed  (windows_placed_r),
    .mem_size_kb     (mem_size_kb_r),
    .machine_variant (machine_variant_r),
    .res             (xres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_kb_r     <= epwm_pkg::SMALL_MEM_KB;
      machine_variant_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        page_r[k] <= epwm_pkg::PAGE_RESET;
        ctrl_r[k] <= (k == 3) ? 8'h00 : 8'h80;
      end
      base_index_r     <= 4'd0;
      windows_placed_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (epwm_pkg::cfg_idx_t'(cfg_index))
          epwm_pkg::CFG_MEM_SIZE_KB: mem_size_kb_r     <= cfg_wdata;
          epwm_pkg::CFG_VARIANT:     machine_variant_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (page_wr) begin
        page_r[sel] <= in_wdata;
      end
      if (ctrl_wr) begin
        ctrl_r[sel]      <= in_wdata;
        base_index_r     <= base_index_nxt;
        windows_placed_r <= 1'b1;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      io_hit_r     <= io_hit;
      io_rdata_r   <= io_rdata;
      if (cmd == epwm_pkg::CMD_MEM) begin
        win_hit_r    <= xres.win_hit;
        phys_addr_r  <= xres.phys_addr;
        phys_valid_r <= xres.phys_valid;
      end else begin
        win_hit_r    <= 1'b0;
        phys_addr_r  <= '0;
        phys_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_io_hit     = io_hit_r;
  assign out_io_rdata   = io_rdata_r;
  assign out_win_hit    = win_hit_r;
  assign out_phys_addr  = phys_addr_r;
  assign out_phys_valid = phys_valid_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_valid_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phys_valid |-> out_win_hit)
    else $error("translated address flagged valid without a window hit");

  a_port_no_window: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd != epwm_pkg::CMD_MEM) |=> !out_win_hit && (out_phys_addr == '0))
    else $error("non-memory transaction reported a window result");

  a_placed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    windows_placed_r |=> windows_placed_r)
    else $error("window placement reverted without reset");

endmodule
